// ===== rtl/cbp_pkg.sv =====
package cbp_pkg;

    localparam int NUM_SYMBOLS   = 256;
    localparam int MAX_CODE_BITS = 64;
    localparam int LEN_FIELD_BITS = 8;

    localparam logic [63:0] CODE_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - MAX_CODE_BITS);
    localparam logic [7:0]  MAX_LEN   = 8'(MAX_CODE_BITS);
    localparam logic [9:0]  SYM_LIMIT = 10'(NUM_SYMBOLS);

    typedef struct packed {
        logic        in_code_phase;
        logic [7:0]  bits_left;
        logic [7:0]  length;
        logic [63:0] code_shift;
        logic [8:0]  symbol_count;
        logic        table_done;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [7:0]  code_length;
        logic [63:0] code_bits;
        logic        too_long;
        logic        last_entry;
    } entry_t;

    localparam parse_state_t STATE_RESET = '{
        in_code_phase: 1'b0,
        bits_left:     8'(LEN_FIELD_BITS),
        length:        8'd0,
        code_shift:    64'd0,
        symbol_count:  9'd0,
        table_done:    1'b0
    };

    // Keep the low n bits of a byte, n in 0..8.
    function automatic logic [7:0] low_bits(input logic [7:0] b, input logic [3:0] n);
        low_bits = b & ~(8'hFF << n);
    endfunction

endpackage

// ===== rtl/cbp_step.sv =====
module cbp_step
    import cbp_pkg::*;
(
    input  parse_state_t st,
    input  logic [7:0]   data_byte,
    output parse_state_t st_next,
    output logic         emit,
    output entry_t       entry
);

    logic [3:0]  len_bits;
    logic [3:0]  rest;
    logic [3:0]  tail;
    logic [3:0]  take;
    logic [15:0] len_window;
    logic [7:0]  len_new;
    logic [7:0]  rest_bits;
    logic [7:0]  short_code;
    logic [71:0] code_window;
    logic [63:0] code_new;
    logic [7:0]  emit_len;
    logic [63:0] emit_code;
    logic [9:0]  count_inc;
    logic        last;

    always_comb begin
        len_bits    = st.bits_left[3:0];
        rest        = 4'd8 - len_bits;
        len_window  = {st.length, data_byte} >> rest;
        len_new     = len_window[7:0];
        rest_bits   = low_bits(data_byte, rest);
        short_code  = rest_bits >> (rest - len_new[3:0]);
        take        = (st.bits_left <= 8'd8) ? st.bits_left[3:0] : 4'd8;
        code_window = {st.code_shift, data_byte} >> (4'd8 - take);
        code_new    = code_window[63:0] & CODE_MASK;
        count_inc   = {1'b0, st.symbol_count} + 10'd1;
        last        = count_inc >= SYM_LIMIT;

        st_next   = st;
        emit      = 1'b0;
        emit_len  = 8'd0;
        emit_code = 64'd0;
        tail      = 4'd0;

        if (!st.in_code_phase) begin
            // Finish the length field, then maybe a short code in the same byte.
            if (len_new == 8'd0) begin
                emit = 1'b1;
                tail = rest;
            end else if (len_new <= {4'd0, rest}) begin
                emit      = 1'b1;
                emit_len  = len_new;
                emit_code = {56'd0, short_code} & CODE_MASK;
                tail      = rest - len_new[3:0];
            end else begin
                st_next.in_code_phase = 1'b1;
                st_next.length        = len_new;
                st_next.bits_left     = len_new - {4'd0, rest};
                st_next.code_shift    = {56'd0, rest_bits} & CODE_MASK;
            end
        end else begin
            if (st.bits_left <= 8'd8) begin
                emit      = 1'b1;
                emit_len  = st.length;
                emit_code = code_new;
                tail      = 4'd8 - take;
            end else begin
                st_next.bits_left  = st.bits_left - 8'd8;
                st_next.code_shift = code_new;
            end
        end

        entry.symbol      = st.symbol_count[7:0];
        entry.code_length = emit_len;
        entry.code_bits   = emit_code;
        entry.too_long    = emit_len > MAX_LEN;
        entry.last_entry  = last;

        if (emit) begin
            // Leftover bits of the byte open the next length field.
            st_next.in_code_phase = 1'b0;
            st_next.length        = low_bits(data_byte, tail);
            st_next.bits_left     = 8'(LEN_FIELD_BITS) - {4'd0, tail};
            st_next.code_shift    = 64'd0;
            st_next.symbol_count  = count_inc[8:0];
            st_next.table_done    = last;
        end

        if (st.table_done) begin
            st_next = st;
            emit    = 1'b0;
        end
    end

endmodule

// ===== rtl/cbp_result_reg.sv =====
module cbp_result_reg
    import cbp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   load,
    input  entry_t load_data,
    output logic   free,
    output logic   m_valid,
    input  logic   m_ready,
    output entry_t m_data
);

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load only when the slot is empty or being drained this cycle.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== rtl/code_table_bitstream_parser.sv =====
// Codebook bitstream parser. Accepts one packed-codebook byte per beat on the
// s_ channel and reads it MSB first; bits run on across bytes with no
// alignment. Each entry is an 8-bit code length followed by that many code
// bits. For each finished entry one beat leaves on the m_ channel with the
// symbol number (counting from 0), the declared length, the code right-aligned
// (first bit read is the most significant; codes longer than 64 bits keep the
// last 64 and raise m_too_long), and m_last_entry on entry 255. Every entry is
// at least 8 bits long, so a byte finishes at most one entry and yields zero or
// one result beats. Once the last entry has gone out, all further bytes are
// accepted and dropped until reset. Throughput is one byte per clock while
// the result register is free: a byte sits in the input register, the whole
// 8-bit step of the parser is resolved in combinational logic, and the entry
// it finishes lands in the result register. The input register advances
// whenever the result register is empty or being drained in the same cycle.
module code_table_bitstream_parser
    import cbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_symbol,
    output logic [7:0]  m_code_length,
    output logic [63:0] m_code_bits,
    output logic        m_too_long,
    output logic        m_last_entry
);

    // Input register: one byte beat waiting for the parser step.
    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;

    // Parser state carried across bytes.
    parse_state_t state_reg;
    parse_state_t state_step;

    logic         step_emit;
    entry_t       step_entry;
    logic         out_free;
    logic         fire;
    logic         load;
    entry_t       m_data;

    cbp_step u_step (
        .st        (state_reg),
        .data_byte (in_byte_reg),
        .st_next   (state_step),
        .emit      (step_emit),
        .entry     (step_entry)
    );

    // Consume the held byte once the result slot can take whatever it yields.
    assign fire    = in_valid_reg && out_free;
    assign load    = fire && step_emit;
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                state_reg <= state_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    cbp_result_reg u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .load_data (step_entry),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_symbol      = m_data.symbol;
    assign m_code_length = m_data.code_length;
    assign m_code_bits   = m_data.code_bits;
    assign m_too_long    = m_data.too_long;
    assign m_last_entry  = m_data.last_entry;

`ifndef SYNTHESIS
    // Once the table is complete, it stays complete until reset.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.table_done |=> state_reg.table_done)
        else $error("table_done cleared without reset");

    // No entry comes out after the table is complete.
    a_no_emit_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.table_done |-> !load)
        else $error("entry emitted after table end");

    // Emitting the last entry closes the table.
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && step_entry.last_entry) |=> state_reg.table_done)
        else $error("last entry did not close the table");

    // A length field always has between one and eight bits to go.
    a_len_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.in_code_phase |->
            (state_reg.bits_left >= 8'd1 && state_reg.bits_left <= 8'd8))
        else $error("length field bit count out of range");

    // In the code phase there is always at least one code bit pending.
    a_code_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.in_code_phase |-> (state_reg.bits_left != 8'd0))
        else $error("code phase with no bits left");
`endif

endmodule
